[src/script_token_lexer_assert.svh]
// Assertion macros shared by the script token lexer RTL.
`ifndef SCRIPT_TOKEN_LEXER_ASSERT_SVH
`define SCRIPT_TOKEN_LEXER_ASSERT_SVH
`ifndef SYNTHESIS
`define STL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define STL_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define STL_ASSERT(label, prop, msg)
`define STL_NEVER(label, expr, msg)
`endif
`endif

[src/stl_pkg.sv]
// Types and constants for the script token lexer.
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

    typedef struct packed {
        logic [7:0] character;
        logic       final_char;
    } char_item_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] start_offset;
        logic [15:0] token_length;
        logic [15:0] line_number;
        logic [15:0] column_number;
        logic        string_closed;
        logic        last_token;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } push_t;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [4:0] KIND_END      = 5'd0;
    localparam logic [4:0] KIND_SPACE    = 5'd1;
    localparam logic [4:0] KIND_PLUS     = 5'd2;
    localparam logic [4:0] KIND_MINUS    = 5'd3;
    localparam logic [4:0] KIND_STAR     = 5'd4;
    localparam logic [4:0] KIND_SLASH    = 5'd5;
    localparam logic [4:0] KIND_PERCENT  = 5'd6;
    localparam logic [4:0] KIND_CARET    = 5'd7;
    localparam logic [4:0] KIND_AMP      = 5'd8;
    localparam logic [4:0] KIND_TILDE    = 5'd9;
    localparam logic [4:0] KIND_ASSIGN   = 5'd10;
    localparam logic [4:0] KIND_EQ_EQ    = 5'd11;
    localparam logic [4:0] KIND_LPAREN   = 5'd12;
    localparam logic [4:0] KIND_RPAREN   = 5'd13;
    localparam logic [4:0] KIND_LBRACK   = 5'd14;
    localparam logic [4:0] KIND_RBRACK   = 5'd15;
    localparam logic [4:0] KIND_LBRACE   = 5'd16;
    localparam logic [4:0] KIND_RBRACE   = 5'd17;
    localparam logic [4:0] KIND_COMMENT  = 5'd18;
    localparam logic [4:0] KIND_STRING   = 5'd19;
    localparam logic [4:0] KIND_NUMBER   = 5'd20;
    localparam logic [4:0] KIND_IDENT    = 5'd21;
    localparam logic [4:0] KIND_KW_FIRST = 5'd22;
    localparam logic [4:0] KIND_UNKNOWN  = 5'd29;

    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_PERCENT    = 8'h25;
    localparam logic [7:0] CH_AMP        = 8'h26;
    localparam logic [7:0] CH_APOS       = 8'h27;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_DIGIT_0    = 8'h30;
    localparam logic [7:0] CH_DIGIT_9    = 8'h39;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_LBRACK     = 8'h5B;
    localparam logic [7:0] CH_RBRACK     = 8'h5D;
    localparam logic [7:0] CH_CARET      = 8'h5E;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;
    localparam logic [7:0] CH_TILDE      = 8'h7E;

    // keywords: if else while for set get when, right-aligned ASCII
    localparam int KW_COUNT  = 7;
    localparam int KW_TEXT_W = 64;
    localparam logic [KW_TEXT_W-1:0] KW_TEXT [KW_COUNT] = '{
        64'h0000_0000_0000_6966,
        64'h0000_0000_656C_7365,
        64'h0000_0077_6869_6C65,
        64'h0000_0000_0066_6F72,
        64'h0000_0000_0073_6574,
        64'h0000_0000_0067_6574,
        64'h0000_0000_7768_656E
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd2, 4'd4, 4'd5, 4'd3, 4'd3, 4'd3, 4'd4
    };

endpackage

`default_nettype wire

[src/stl_front.sv]
// Lexer front end: scans characters and builds up to two tokens per transaction.
`timescale 1ns / 1ps
`default_nettype none
`include "script_token_lexer_assert.svh"

module stl_front
    import stl_pkg::*;
#(
    parameter int COUNT_WIDTH   = 16,
    parameter int KEYWORD_CHARS = 5
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       src_valid,
    input  logic       src_stall,
    input  char_item_t src_data,
    output push_t      push
);

    localparam int CW      = COUNT_WIDTH;
    localparam int KW_BITS = 8 * KEYWORD_CHARS;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_STRING,
        MODE_NUMBER,
        MODE_IDENT
    } mode_t;

    mode_t               mode_reg,   mode_next;
    logic [CW-1:0]       pos_reg,    pos_next;
    logic [CW-1:0]       tstart_reg, tstart_next;
    logic [CW-1:0]       run_reg,    run_next;
    logic [KW_BITS-1:0]  kw_reg,     kw_next;
    logic                peq_reg,    peq_next;
    logic                squote_reg, squote_next;
    logic [CW-1:0]       line_reg,   line_next;
    logic [CW-1:0]       col_reg,    col_next;
    logic [CW-1:0]       sline_reg,  sline_next;
    logic [CW-1:0]       scol_reg,   scol_next;

    logic          accept;
    logic [7:0]    c;
    logic [7:0]    quote_char;
    logic [CW-1:0] run_inc;
    logic          done;
    logic          e1_v, e2_v, e3_v;
    token_t        e1, e2, e3;
    logic [4:0]    e2_kind;
    logic [CW-1:0] e2_len;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9;
    endfunction

    function automatic logic is_alpha(input logic [7:0] ch);
        return (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) || (ch >= CH_UPPER_A && ch <= CH_UPPER_Z);
    endfunction

    function automatic token_t make_token(
        input logic [4:0]    kind,
        input logic [CW-1:0] start,
        input logic [CW-1:0] len,
        input logic [CW-1:0] line,
        input logic [CW-1:0] col,
        input logic          closed
    );
        token_t t;
        t.token_kind    = kind;
        t.start_offset  = 16'(start);
        t.token_length  = 16'(len);
        t.line_number   = 16'(line);
        t.column_number = 16'(col);
        t.string_closed = closed;
        t.last_token    = 1'b0;
        return t;
    endfunction

    function automatic logic [4:0] ident_kind(
        input logic [KW_BITS-1:0] kw,
        input logic [CW-1:0]      run
    );
        logic [4:0] kind;
        kind = KIND_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (run == CW'(KW_LEN[k]) && KW_TEXT_W'(kw) == KW_TEXT[k]) begin
                kind = KIND_KW_FIRST + 5'(k);
            end
        end
        return kind;
    endfunction

    function automatic logic [4:0] char_kind(input logic [7:0] ch);
        logic [4:0] kind;
        case (ch) inside
            CH_SPACE, CH_TAB, CH_CR, CH_NEWLINE: kind = KIND_SPACE;
            CH_PLUS:    kind = KIND_PLUS;
            CH_MINUS:   kind = KIND_MINUS;
            CH_STAR:    kind = KIND_STAR;
            CH_SLASH:   kind = KIND_SLASH;
            CH_PERCENT: kind = KIND_PERCENT;
            CH_CARET:   kind = KIND_CARET;
            CH_AMP:     kind = KIND_AMP;
            CH_TILDE:   kind = KIND_TILDE;
            CH_LPAREN:  kind = KIND_LPAREN;
            CH_RPAREN:  kind = KIND_RPAREN;
            CH_LBRACK:  kind = KIND_LBRACK;
            CH_RBRACK:  kind = KIND_RBRACK;
            CH_LBRACE:  kind = KIND_LBRACE;
            CH_RBRACE:  kind = KIND_RBRACE;
            default:    kind = KIND_UNKNOWN;
        endcase
        return kind;
    endfunction

    assign accept     = src_valid && !src_stall;
    assign c          = src_data.character;
    assign quote_char = squote_reg ? CH_APOS : CH_QUOTE;
    assign run_inc    = sat_inc(run_reg);

    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        tstart_next = tstart_reg;
        run_next    = run_reg;
        kw_next     = kw_reg;
        peq_next    = peq_reg;
        squote_next = squote_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        sline_next  = sline_reg;
        scol_next   = scol_reg;
        done    = 1'b0;
        e1_v    = 1'b0;
        e2_v    = 1'b0;
        e3_v    = 1'b0;
        e1      = '0;
        e2      = '0;
        e3      = '0;
        e2_kind = KIND_UNKNOWN;
        e2_len  = CW'(1);

        // close or extend the token in progress (old start fields)
        if (peq_reg) begin
            peq_next = 1'b0;
            e1_v     = 1'b1;
            if (c == CH_EQUAL) begin
                e1   = make_token(KIND_EQ_EQ, tstart_reg, CW'(2), sline_reg, scol_reg, 1'b0);
                done = 1'b1;
            end else begin
                e1 = make_token(KIND_ASSIGN, tstart_reg, CW'(1), sline_reg, scol_reg, 1'b0);
            end
        end else begin
            unique case (mode_reg)
                MODE_COMMENT: begin
                    if (c == CH_NEWLINE || c == CH_NUL) begin
                        e1_v      = 1'b1;
                        e1        = make_token(KIND_COMMENT, tstart_reg, run_reg, sline_reg,
                                               scol_reg, 1'b0);
                        mode_next = MODE_IDLE;
                    end else begin
                        run_next = run_inc;
                        done     = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if (c == quote_char) begin
                        run_next  = run_inc;
                        e1_v      = 1'b1;
                        e1        = make_token(KIND_STRING, tstart_reg, run_inc, sline_reg,
                                               scol_reg, 1'b1);
                        mode_next = MODE_IDLE;
                        done      = 1'b1;
                    end else if (c == CH_NUL) begin
                        e1_v      = 1'b1;
                        e1        = make_token(KIND_STRING, tstart_reg, run_reg, sline_reg,
                                               scol_reg, 1'b0);
                        mode_next = MODE_IDLE;
                    end else begin
                        run_next = run_inc;
                        done     = 1'b1;
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(c) || c == CH_DOT) begin
                        run_next = run_inc;
                        done     = 1'b1;
                    end else begin
                        e1_v      = 1'b1;
                        e1        = make_token(KIND_NUMBER, tstart_reg, run_reg, sline_reg,
                                               scol_reg, 1'b0);
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_IDENT: begin
                    if (is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE) begin
                        if (run_reg < CW'(KEYWORD_CHARS)) begin
                            kw_next = {kw_reg[KW_BITS-9:0], c};
                        end
                        run_next = run_inc;
                        done     = 1'b1;
                    end else begin
                        e1_v      = 1'b1;
                        e1        = make_token(ident_kind(kw_reg, run_reg), tstart_reg, run_reg,
                                               sline_reg, scol_reg, 1'b0);
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_IDLE: ;
                default: ;
            endcase
        end

        // this character starts a new token
        if (!done) begin
            tstart_next = pos_reg;
            sline_next  = line_reg;
            scol_next   = col_reg;
            run_next    = CW'(1);
            unique case (c) inside
                CH_NUL: begin
                    e2_v    = 1'b1;
                    e2_kind = KIND_END;
                    e2_len  = '0;
                end
                CH_EQUAL: peq_next = 1'b1;
                CH_HASH:  mode_next = MODE_COMMENT;
                CH_QUOTE: begin
                    mode_next   = MODE_STRING;
                    squote_next = 1'b0;
                end
                CH_APOS: begin
                    mode_next   = MODE_STRING;
                    squote_next = 1'b1;
                end
                [CH_DIGIT_0:CH_DIGIT_9]: mode_next = MODE_NUMBER;
                [CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]: begin
                    mode_next = MODE_IDENT;
                    kw_next   = KW_BITS'(c);
                end
                default: begin
                    e2_v    = 1'b1;
                    e2_kind = char_kind(c);
                end
            endcase
            e2 = make_token(e2_kind, pos_reg, e2_len, line_reg, col_reg, 1'b0);
        end

        if (c == CH_NEWLINE) begin
            line_next = sat_inc(line_reg);
            col_next  = CW'(1);
        end else begin
            col_next = sat_inc(col_reg);
        end
        pos_next = sat_inc(pos_reg);

        // end of source: flush whatever is open and start over
        if (src_data.final_char) begin
            if (peq_next) begin
                e3_v = 1'b1;
                e3   = make_token(KIND_ASSIGN, tstart_next, CW'(1), sline_next, scol_next, 1'b0);
            end else begin
                e3_v = mode_next != MODE_IDLE;
                unique case (mode_next)
                    MODE_COMMENT: e3 = make_token(KIND_COMMENT, tstart_next, run_next,
                                                  sline_next, scol_next, 1'b0);
                    MODE_STRING:  e3 = make_token(KIND_STRING, tstart_next, run_next,
                                                  sline_next, scol_next, 1'b0);
                    MODE_NUMBER:  e3 = make_token(KIND_NUMBER, tstart_next, run_next,
                                                  sline_next, scol_next, 1'b0);
                    MODE_IDENT:   e3 = make_token(ident_kind(kw_next, run_next), tstart_next,
                                                  run_next, sline_next, scol_next, 1'b0);
                    MODE_IDLE:    ;
                    default:      ;
                endcase
            end
            if (e3_v) begin
                e3.last_token = 1'b1;
            end else if (e2_v) begin
                e2.last_token = 1'b1;
            end else if (e1_v) begin
                e1.last_token = 1'b1;
            end
            mode_next   = MODE_IDLE;
            pos_next    = '0;
            tstart_next = '0;
            run_next    = '0;
            kw_next     = '0;
            peq_next    = 1'b0;
            squote_next = 1'b0;
            line_next   = CW'(1);
            col_next    = CW'(1);
            sline_next  = CW'(1);
            scol_next   = CW'(1);
        end

        push.count  = accept ? (2'(e1_v) + 2'(e2_v) + 2'(e3_v)) : 2'd0;
        push.first  = e1_v ? e1 : (e2_v ? e2 : e3);
        push.second = (e1_v && e2_v) ? e2 : e3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            tstart_reg <= '0;
            run_reg    <= '0;
            kw_reg     <= '0;
            peq_reg    <= 1'b0;
            squote_reg <= 1'b0;
            line_reg   <= CW'(1);
            col_reg    <= CW'(1);
            sline_reg  <= CW'(1);
            scol_reg   <= CW'(1);
        end else if (accept) begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            tstart_reg <= tstart_next;
            run_reg    <= run_next;
            kw_reg     <= kw_next;
            peq_reg    <= peq_next;
            squote_reg <= squote_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            sline_reg  <= sline_next;
            scol_reg   <= scol_next;
        end
    end

    `STL_NEVER(a_peq_idle, peq_reg && mode_reg != MODE_IDLE, "held '=' while a token is open")
    `STL_NEVER(a_open_len, mode_reg != MODE_IDLE && run_reg == '0, "open token with zero length")
    `STL_NEVER(a_push_cnt, push.count == 2'd3, "more than two tokens from one character")

endmodule

`default_nettype wire

[src/stl_queue.sv]
// Token queue: takes up to two tokens per cycle, delivers one per cycle while tok_stall is low.
`timescale 1ns / 1ps
`default_nettype none
`include "script_token_lexer_assert.svh"

module stl_queue
    import stl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  push_t  push,
    output logic   full,
    output logic   tok_valid,
    output token_t tok_data,
    input  logic   tok_stall
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    token_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_inc;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               pop;

    assign tok_valid  = count_reg != '0;
    assign tok_data   = mem[rd_ptr_reg];
    assign pop        = tok_valid && !tok_stall;
    // room for a full two-token transaction is required before accepting
    assign full       = count_reg > CNT_W'(QUEUE_DEPTH - 2);
    assign wr_ptr_inc = wr_ptr_reg + 1'b1;

    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
    assign count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_inc] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    `STL_NEVER(a_overflow, count_reg > CNT_W'(QUEUE_DEPTH), "token queue overflow")
    `STL_NEVER(a_push_full, push.count != 2'd0 && full, "push into a full token queue")
    `STL_ASSERT(a_ptr_gap, (wr_ptr_reg - rd_ptr_reg) == PTR_W'(count_reg), "queue pointer gap")

endmodule

`default_nettype wire

[src/script_token_lexer.sv]
// Top level of the script token lexer: scanner front end and token queue.
`timescale 1ns / 1ps
`default_nettype none

// Streaming lexer. One source byte is taken per clock on src while src_stall is low;
// classified tokens leave on tok in source order, each carrying kind, start offset,
// length, line and column. A byte yields zero, one or two tokens; the scanner writes
// them into a four-entry queue in the same cycle, and the queue hands out one token per
// cycle while tok is not stalled. Input is stalled while fewer than two queue entries
// are free. With an empty queue, the first token of a byte reaches tok the cycle after
// the byte is taken, and a second token follows once the first leaves tok. Marking a byte
// with final_char flushes any open token, flags the last token, and resets the scanner.
module script_token_lexer
    import stl_pkg::*;
#(
    parameter int COUNT_WIDTH   = 16,
    parameter int KEYWORD_CHARS = 5
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       src_valid,
    output logic       src_stall,
    input  char_item_t src_data,
    output logic       tok_valid,
    input  logic       tok_stall,
    output token_t     tok_data
);

    push_t push;

    stl_front #(
        .COUNT_WIDTH   (COUNT_WIDTH),
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .push      (push)
    );

    stl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (src_stall),
        .tok_valid (tok_valid),
        .tok_data  (tok_data),
        .tok_stall (tok_stall)
    );

endmodule

`default_nettype wire
